FILE: rtl/grd_pkg.sv
package grd_pkg;

  localparam int PortCountDef = 4;
  localparam int PortW        = 2;
  localparam int IdW          = 3;

  // configuration register indexes
  localparam logic [2:0] RegMainMode   = 3'd0;
  localparam logic [2:0] RegCstickMode = 3'd1;
  localparam logic [2:0] RegLeftMode   = 3'd2;
  localparam logic [2:0] RegRightMode  = 3'd3;
  localparam logic [2:0] RegMainDz     = 3'd4;
  localparam logic [2:0] RegCstickDz   = 3'd5;
  localparam logic [2:0] RegLeftDz     = 3'd6;
  localparam logic [2:0] RegRightDz    = 3'd7;

  localparam logic [7:0] Neutral = 8'd127;
  localparam logic [7:0] DzReset = 8'd35;

  // inputs of one stick lane
  typedef struct packed {
    logic       mode;
    logic [7:0] dz;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] cx;
    logic [7:0] cy;
  } grd_stick_in_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] dz;
    logic [7:0] t;
    logic [7:0] c;
  } grd_trig_in_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_OUT
  } grd_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_SQRT,
    L_MUL,
    L_DIV,
    L_WAIT,
    L_DONE
  } grd_lane_state_t;

  function automatic logic [7:0] grd_clamp8(input logic signed [40:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 41'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

endpackage

FILE: rtl/grd_divider.sv
// Restoring divider, one quotient bit per cycle. Unsigned magnitudes.
module grd_divider
  import grd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [24:0] den,
  output logic        done,
  output logic [39:0] quo,
  output logic        rem_nz
);
  logic [39:0] q_r, q_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [25:0] trial;

  assign trial = {rem_r[24:0], q_r[39]} - {1'b0, den};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[25]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[24:0], q_r[39]};
        q_nxt   = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = busy_r && (cnt_r == 6'd1);
  assign quo    = q_nxt;
  assign rem_nz = (rem_nxt != '0);
endmodule

FILE: rtl/grd_stick_lane.sv
// One stick: iterative square root of S<<16, then, unless bypassed, two serial divisions
// (x on one divider, y on another).
module grd_stick_lane
  import grd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  grd_stick_in_t lin,
  output logic          done,
  output logic [7:0]    ox,
  output logic [7:0]    oy
);
  grd_lane_state_t st_r, st_nxt;
  logic signed [8:0]  dx_r, dy_r;
  logic [32:0]        v_r;     // sqrt remainder
  logic [33:0]        res_r;   // root, final value up to 17 bits
  logic [4:0]         it_r;
  logic [34:0]        bitv;
  logic [16:0]        den_r;
  logic [24:0]        dfull_r;
  logic signed [26:0] base_r;
  logic [39:0]        numx, numy;
  logic               negx_r, negy_r;
  logic               byp_r;
  logic [7:0]         bx_r, by_r;
  logic [7:0]         ox_r, oy_r;
  logic               startd;
  logic               dvx_done, dvy_done;
  logic [39:0]        qx, qy;
  logic               rnx, rny;
  logic [34:0]        sum;
  logic signed [40:0] vx, vy;
  logic [15:0]        dzsq;
  logic [8:0]         dxa, dya;

  assign bitv = 35'd1 << {it_r, 1'b0};
  assign sum  = {1'b0, res_r} + bitv;
  assign dzsq = lin.dz * lin.dz;
  assign dxa  = dx_r[8] ? 9'(-dx_r) : 9'(dx_r);
  assign dya  = dy_r[8] ? 9'(-dy_r) : 9'(dy_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      L_IDLE: if (start) st_nxt = L_SQRT;
      L_SQRT: if (it_r == 5'd0) st_nxt = L_MUL;
      L_MUL:  st_nxt = byp_r ? L_DONE : L_DIV;
      L_DIV:  st_nxt = L_WAIT;
      L_WAIT: if (dvx_done && dvy_done) st_nxt = L_DONE;
      L_DONE: st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  assign startd = (st_r == L_DIV);

  assign vx = negx_r ? -$signed({1'b0, qx}) - (rnx ? 41'sd1 : 41'sd0) : $signed({1'b0, qx});
  assign vy = negy_r ? -$signed({1'b0, qy}) - (rny ? 41'sd1 : 41'sd0) : $signed({1'b0, qy});

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= L_IDLE;
    else        st_r <= st_nxt;
    if (st_r == L_IDLE && start) begin
      dx_r  <= $signed({1'b0, lin.x}) - $signed({1'b0, lin.cx});
      dy_r  <= $signed({1'b0, lin.y}) - $signed({1'b0, lin.cy});
      res_r <= '0;
      it_r  <= 5'd17;
      byp_r <= !lin.mode;
      bx_r  <= lin.x;
      by_r  <= lin.y;
      den_r <= (lin.dz == 8'd255) ? 17'd1 : {9'd0, 8'd255 - lin.dz};
    end
    if (st_r == L_SQRT) begin
      if (it_r == 5'd17) begin
        // first cycle: form S and deadzone test
        v_r <= {(17'(dxa * dxa) + 17'(dya * dya)), 16'd0};
        if (!byp_r && ((17'(dxa * dxa) + 17'(dya * dya)) < {1'b0, dzsq} ||
            (dxa == 9'd0 && dya == 9'd0))) begin
          byp_r <= 1'b1;
          bx_r  <= Neutral;
          by_r  <= Neutral;
        end
        it_r <= 5'd16;
      end else begin
        if ({2'b0, v_r} >= sum) begin
          v_r   <= 33'({2'b0, v_r} - sum);
          res_r <= 34'((res_r >> 1) + bitv);
        end else begin
          res_r <= res_r >> 1;
        end
        if (it_r != 5'd0) it_r <= it_r - 5'd1;
      end
    end
    if (st_r == L_MUL) begin
      base_r  <= 27'sd255 * ($signed({10'd0, res_r[16:0]}) -
                             $signed({11'd0, lin.dz, 8'd0}));
      dfull_r <= 25'(den_r * res_r[16:0]);
    end
    if (st_r == L_DIV) begin
      negx_r <= (base_r < 0) ^ dx_r[8];
      negy_r <= (base_r < 0) ^ dy_r[8];
    end
    if (dvx_done) begin
      ox_r <= grd_clamp8(vx + 41'sd127);
      oy_r <= grd_clamp8(vy + 41'sd127);
    end
    if (st_r == L_MUL && byp_r) begin
      ox_r <= bx_r;
      oy_r <= by_r;
    end
  end

  logic [26:0] babs;
  assign babs = base_r[26] ? 27'(-base_r) : 27'(base_r);
  assign numx = 40'(babs * dxa);
  assign numy = 40'(babs * dya);

  grd_divider u_dvx (
    .clk(clk), .rst_n(rst_n), .start(startd), .num(numx), .den(dfull_r),
    .done(dvx_done), .quo(qx), .rem_nz(rnx)
  );
  grd_divider u_dvy (
    .clk(clk), .rst_n(rst_n), .start(startd), .num(numy), .den(dfull_r),
    .done(dvy_done), .quo(qy), .rem_nz(rny)
  );

  assign done = (st_r == L_DONE);
  assign ox   = ox_r;
  assign oy   = oy_r;
endmodule

FILE: rtl/grd_trig_lane.sv
// One trigger: one-sided deadzone, rescale by a serial divider.
module grd_trig_lane
  import grd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  grd_trig_in_t tin,
  output logic [7:0]   o
);
  logic               go_r;
  logic [39:0]        num_r;
  logic [24:0]        den_r;
  logic               dv_done, rnz;
  logic [39:0]        q;
  logic [7:0]         o_r;
  logic signed [8:0]  gap;

  assign gap = $signed({1'b0, tin.t}) - $signed({1'b0, tin.c});

  always_ff @(posedge clk) begin
    if (!rst_n) go_r <= 1'b0;
    else        go_r <= start && tin.mode && !(gap < $signed({1'b0, tin.dz}) || gap == 9'sd0);
    if (start) begin
      num_r <= 40'(17'd255 * 9'(gap - $signed({1'b0, tin.dz})));
      den_r <= (tin.dz == 8'd255) ? 25'd1 : 25'(8'd255 - tin.dz);
      if (!tin.mode) o_r <= tin.t;
      else           o_r <= 8'd0;
    end
    if (dv_done) o_r <= (q > 40'd255) ? 8'd255 : q[7:0];
  end

  grd_divider u_dv (
    .clk(clk), .rst_n(rst_n), .start(go_r), .num(num_r), .den(den_r),
    .done(dv_done), .quo(q), .rem_nz(rnz)
  );

  assign o = o_r;
endmodule

FILE: rtl/gamepad_radial_deadzone_unit.sv
// Gamepad radial deadzone unit.
// Input stream in_*: one raw controller sample per transfer. tdata from bit 0:
//   port[1:0], present, buttons[15:0], main_x, main_y, cstick_x, cstick_y,
//   left_trigger, right_trigger (zero padded to 72 bits).
// Output stream out_*: one report per sample. tdata from bit 0: report_id[2:0],
//   out_buttons, out_main_x, out_main_y, out_cstick_x, out_cstick_y, out_left,
//   out_right (zero padded to 72 bits).
// Config channel cfg_*: index 0..3 modes, 4..7 deadzones; write while idle.
// Two stick lanes and two trigger lanes run side by side, a merge stage forms
// the report and updates calibration. A present sample raises out_tvalid once
// both stick lanes are done (square root, then the bit-serial divide unless a
// stick bypasses it) and a fixed countdown that covers the trigger dividers
// has run out. An absent sample passes through the work state to out_tvalid
// without starting the lanes. One sample is in flight; in_tready returns in
// the cycle after the report transfer.
// Reset clears connected flags and calibration and restores default config.
// When the receiver stalls, the report holds in the output register and
// in_tready stays low until it is taken.
module gamepad_radial_deadzone_unit
  import grd_pkg::*;
#(
  parameter int PORT_COUNT = PortCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // port, present, buttons, main_x..right_trigger
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // report_id, out_buttons, out_main_x..out_right
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  grd_state_t st_r, st_nxt;
  logic [3:0] mode_r;
  logic [7:0] dz_r [4];
  logic [47:0] cal_r [PORT_COUNT];
  logic [PORT_COUNT-1:0] conn_r;
  logic [71:0] smp_r;
  logic [71:0] out_r;
  logic start_r;
  logic [5:0] wait_r;
  logic sdone;
  logic [7:0] mx, my, cx, cy, lo, ro;
  logic [47:0] cal;
  logic [PortW-1:0] port;
  logic in_range, act;
  grd_stick_in_t sm, sc;
  grd_trig_in_t  tl, tr;

  assign port     = smp_r[1:0];
  assign in_range = ({1'b0, port} < 3'(PORT_COUNT));
  assign cal      = in_range ? cal_r[port] : '0;
  assign act      = in_range && smp_r[2];

  assign in_tready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_WORK;
      ST_WORK: if (!act || (!start_r && sdone && wait_r == 6'd0)) st_nxt = ST_OUT;
      ST_OUT:  if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = out_r;

  assign sm = '{mode: mode_r[0], dz: dz_r[0], x: smp_r[26:19], y: 8'd255 - smp_r[34:27],
                cx: cal[7:0], cy: cal[15:8]};
  assign sc = '{mode: mode_r[1], dz: dz_r[1], x: smp_r[42:35], y: smp_r[50:43],
                cx: cal[23:16], cy: cal[31:24]};
  assign tl = '{mode: mode_r[2], dz: dz_r[2], t: smp_r[58:51], c: cal[39:32]};
  assign tr = '{mode: mode_r[3], dz: dz_r[3], t: smp_r[66:59], c: cal[47:40]};

  logic md, cd;
  logic md_r, cd_r;
  grd_stick_lane u_main (.clk(clk), .rst_n(rst_n), .start(start_r), .lin(sm),
                         .done(md), .ox(mx), .oy(my));
  grd_stick_lane u_cstk (.clk(clk), .rst_n(rst_n), .start(start_r), .lin(sc),
                         .done(cd), .ox(cx), .oy(cy));
  grd_trig_lane  u_left (.clk(clk), .rst_n(rst_n), .start(start_r), .tin(tl), .o(lo));
  grd_trig_lane  u_rght (.clk(clk), .rst_n(rst_n), .start(start_r), .tin(tr), .o(ro));

  // a stick may skip its divide; the wait covers the trigger divider tail
  assign sdone = md_r && cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      mode_r  <= '1;
      for (int i = 0; i < 4; i++) dz_r[i] <= DzReset;
      for (int i = 0; i < PORT_COUNT; i++) cal_r[i] <= '0;
      conn_r  <= '0;
      start_r <= 1'b0;
      md_r    <= 1'b0;
      cd_r    <= 1'b0;
      wait_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      // start the lanes only for a present sample on a valid port
      start_r <= (st_r == ST_IDLE) && in_tvalid && in_tready && in_tdata[2] &&
                 ({1'b0, in_tdata[1:0]} < 3'(PORT_COUNT));
      if (start_r) begin
        md_r <= 1'b0; cd_r <= 1'b0; wait_r <= 6'd41;
      end else begin
        if (md) md_r <= 1'b1;
        if (cd) cd_r <= 1'b1;
        if (wait_r != 6'd0) wait_r <= wait_r - 6'd1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          RegMainMode:   mode_r[0] <= cfg_data[0];
          RegCstickMode: mode_r[1] <= cfg_data[0];
          RegLeftMode:   mode_r[2] <= cfg_data[0];
          RegRightMode:  mode_r[3] <= cfg_data[0];
          RegMainDz:     dz_r[0] <= cfg_data;
          RegCstickDz:   dz_r[1] <= cfg_data;
          RegLeftDz:     dz_r[2] <= cfg_data;
          RegRightDz:    dz_r[3] <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == ST_WORK && st_nxt == ST_OUT && in_range) begin
        if (!smp_r[2]) conn_r[port] <= 1'b0;
        else if (!conn_r[port]) begin
          conn_r[port] <= 1'b1;
          cal_r[port]  <= {smp_r[66:59], smp_r[58:51], smp_r[50:43],
                           smp_r[42:35], smp_r[34:27], smp_r[26:19]};
        end
      end
    end
    if (st_r == ST_IDLE && in_tvalid) smp_r <= in_tdata;
    if (st_r == ST_WORK) begin
      if (act)
        out_r <= {5'd0, ro, lo, cy, cx, my, mx, smp_r[18:3], 3'(port) + 3'd1};
      else
        out_r <= {5'd0, 8'd0, 8'd0, Neutral, Neutral, Neutral, Neutral, 16'd0,
                  3'(port) + 3'd1};
    end
  end
endmodule
